### hw/rtl/rtg_pkg.sv
// ----------------------------------------------------------------------------
// rtg_pkg: shared definitions for the Raptor triple generator
// Register indices, arithmetic constants, the V0/V1 random tables, the degree
// table and the remainder step functions.
// ----------------------------------------------------------------------------
package rtg_pkg;

   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SYSTEMATIC_INDEX = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INTERMEDIATE     = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_Q_MODULUS        = 2'd2;

   localparam logic [15:0] J_RESET = 16'd0;
   localparam logic [13:0] L_RESET = 14'd3;
   localparam logic [15:0] Q_RESET = 16'd65521;

   localparam logic [31:0] A_OFFSET = 32'd53591;
   localparam logic [31:0] A_FACTOR = 32'd997;
   localparam logic [31:0] B_FACTOR = 32'd10267;

   localparam int DIVIDEND_WIDTH = 32;
   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = DIVIDEND_WIDTH / BITS_PER_STAGE;

   localparam logic [31:0] V0 [256] = '{
      32'd251291136, 32'd3952231631, 32'd3370958628, 32'd4070167936, 32'd123631495,
      32'd3351110283, 32'd3218676425, 32'd2011642291, 32'd774603218, 32'd2402805061,
      32'd1004366930, 32'd1843948209, 32'd428891132, 32'd3746331984, 32'd1591258008,
      32'd3067016507, 32'd1433388735, 32'd504005498, 32'd2032657933, 32'd3419319784,
      32'd2805686246, 32'd3102436986, 32'd3808671154, 32'd2501582075, 32'd3978944421,
      32'd246043949, 32'd4016898363, 32'd649743608, 32'd1974987508, 32'd2651273766,
      32'd2357956801, 32'd689605112, 32'd715807172, 32'd2722736134, 32'd191939188,
      32'd3535520147, 32'd3277019569, 32'd1470435941, 32'd3763101702, 32'd3232409631,
      32'd122701163, 32'd3920852693, 32'd782246947, 32'd372121310, 32'd2995604341,
      32'd2045698575, 32'd2332962102, 32'd4005368743, 32'd218596347, 32'd3415381967,
      32'd4207612806, 32'd861117671, 32'd3676575285, 32'd2581671944, 32'd3312220480,
      32'd681232419, 32'd307306866, 32'd4112503940, 32'd1158111502, 32'd709227802,
      32'd2724140433, 32'd4201101115, 32'd4215970289, 32'd4048876515, 32'd3031661061,
      32'd1909085522, 32'd510985033, 32'd1361682810, 32'd129243379, 32'd3142379587,
      32'd2569842483, 32'd3033268270, 32'd1658118006, 32'd932109358, 32'd1982290045,
      32'd2983082771, 32'd3007670818, 32'd3448104768, 32'd683749698, 32'd778296777,
      32'd1399125101, 32'd1939403708, 32'd1692176003, 32'd3868299200, 32'd1422476658,
      32'd593093658, 32'd1878973865, 32'd2526292949, 32'd1591602827, 32'd3986158854,
      32'd3964389521, 32'd2695031039, 32'd1942050155, 32'd424618399, 32'd1347204291,
      32'd2669179716, 32'd2434425874, 32'd2540801947, 32'd1384069776, 32'd4123580443,
      32'd1523670218, 32'd2708475297, 32'd1046771089, 32'd2229796016, 32'd1255426612,
      32'd4213663089, 32'd1521339547, 32'd3041843489, 32'd420130494, 32'd10677091,
      32'd515623176, 32'd3457502702, 32'd2115821274, 32'd2720124766, 32'd3242576090,
      32'd854310108, 32'd425973987, 32'd325832382, 32'd1796851292, 32'd2462744411,
      32'd1976681690, 32'd1408671665, 32'd1228817808, 32'd3917210003, 32'd263976645,
      32'd2593736473, 32'd2471651269, 32'd4291353919, 32'd650792940, 32'd1191583883,
      32'd3046561335, 32'd2466530435, 32'd2545983082, 32'd969168436, 32'd2019348792,
      32'd2268075521, 32'd1169345068, 32'd3250240009, 32'd3963499681, 32'd2560755113,
      32'd911182396, 32'd760842409, 32'd3569308693, 32'd2687243553, 32'd381854665,
      32'd2613828404, 32'd2761078866, 32'd1456668111, 32'd883760091, 32'd3294951678,
      32'd1604598575, 32'd1985308198, 32'd1014570543, 32'd2724959607, 32'd3062518035,
      32'd3115293053, 32'd138853680, 32'd4160398285, 32'd3322241130, 32'd2068983570,
      32'd2247491078, 32'd3669524410, 32'd1575146607, 32'd828029864, 32'd3732001371,
      32'd3422026452, 32'd3370954177, 32'd4006626915, 32'd543812220, 32'd1243116171,
      32'd3928372514, 32'd2791443445, 32'd4081325272, 32'd2280435605, 32'd885616073,
      32'd616452097, 32'd3188863436, 32'd2780382310, 32'd2340014831, 32'd1208439576,
      32'd258356309, 32'd3837963200, 32'd2075009450, 32'd3214181212, 32'd3303882142,
      32'd880813252, 32'd1355575717, 32'd207231484, 32'd2420803184, 32'd358923368,
      32'd1617557768, 32'd3272161958, 32'd1771154147, 32'd2842106362, 32'd1751209208,
      32'd1421030790, 32'd658316681, 32'd194065839, 32'd3241510581, 32'd38625260,
      32'd301875395, 32'd4176141739, 32'd297312930, 32'd2137802113, 32'd1502984205,
      32'd3669376622, 32'd3728477036, 32'd234652930, 32'd2213589897, 32'd2734638932,
      32'd1129721478, 32'd3187422815, 32'd2859178611, 32'd3284308411, 32'd3819792700,
      32'd3557526733, 32'd451874476, 32'd1740576081, 32'd3592838701, 32'd1709429513,
      32'd3702918379, 32'd3533351328, 32'd1641660745, 32'd179350258, 32'd2380520112,
      32'd3936163904, 32'd3685256204, 32'd3156252216, 32'd1854258901, 32'd2861641019,
      32'd3176611298, 32'd834787554, 32'd331353807, 32'd517858103, 32'd3010168884,
      32'd4012642001, 32'd2217188075, 32'd3756943137, 32'd3077882590, 32'd2054995199,
      32'd3081443129, 32'd3895398812, 32'd1141097543, 32'd2376261053, 32'd2626898255,
      32'd2554703076, 32'd401233789, 32'd1460049922, 32'd678083952, 32'd1064990737,
      32'd940909784, 32'd1673396780, 32'd528881783, 32'd1712547446, 32'd3629685652,
      32'd1358307511
   };

   localparam logic [31:0] V1 [256] = '{
      32'd807385413, 32'd2043073223, 32'd3336749796, 32'd1302105833, 32'd2278607931,
      32'd541015020, 32'd1684564270, 32'd372709334, 32'd3508252125, 32'd1768346005,
      32'd1270451292, 32'd2603029534, 32'd2049387273, 32'd3891424859, 32'd2152948345,
      32'd4114760273, 32'd915180310, 32'd3754787998, 32'd700503826, 32'd2131559305,
      32'd1308908630, 32'd224437350, 32'd4065424007, 32'd3638665944, 32'd1679385496,
      32'd3431345226, 32'd1779595665, 32'd3068494238, 32'd1424062773, 32'd1033448464,
      32'd4050396853, 32'd3302235057, 32'd420600373, 32'd2868446243, 32'd311689386,
      32'd259047959, 32'd4057180909, 32'd1575367248, 32'd4151214153, 32'd110249784,
      32'd3006865921, 32'd4293710613, 32'd3501256572, 32'd998007483, 32'd499288295,
      32'd1205710710, 32'd2997199489, 32'd640417429, 32'd3044194711, 32'd486690751,
      32'd2686640734, 32'd2394526209, 32'd2521660077, 32'd49993987, 32'd3843885867,
      32'd4201106668, 32'd415906198, 32'd19296841, 32'd2402488407, 32'd2137119134,
      32'd1744097284, 32'd579965637, 32'd2037662632, 32'd852173610, 32'd2681403713,
      32'd1047144830, 32'd2982173936, 32'd910285038, 32'd4187576520, 32'd2589870048,
      32'd989448887, 32'd3292758024, 32'd506322719, 32'd176010738, 32'd1865471968,
      32'd2619324712, 32'd564829442, 32'd1996870325, 32'd339697593, 32'd4071072948,
      32'd3618966336, 32'd2111320126, 32'd1093955153, 32'd957978696, 32'd892010560,
      32'd1854601078, 32'd1873407527, 32'd2498544695, 32'd2694156259, 32'd1927339682,
      32'd1650555729, 32'd183933047, 32'd3061444337, 32'd2067387204, 32'd228962564,
      32'd3904109414, 32'd1595995433, 32'd1780701372, 32'd2463145963, 32'd307281463,
      32'd3237929991, 32'd3852995239, 32'd2398693510, 32'd3754138664, 32'd522074127,
      32'd146352474, 32'd4104915256, 32'd3029415884, 32'd3545667983, 32'd332038910,
      32'd976628269, 32'd3123492423, 32'd3041418372, 32'd2258059298, 32'd2139377204,
      32'd3243642973, 32'd3226247917, 32'd3674004636, 32'd2698992189, 32'd3453843574,
      32'd1963216666, 32'd3509855005, 32'd2358481858, 32'd747331248, 32'd1957348676,
      32'd1097574450, 32'd2435697214, 32'd3870972145, 32'd1888833893, 32'd2914085525,
      32'd4161315584, 32'd1273113343, 32'd3269644828, 32'd3681293816, 32'd412536684,
      32'd1156034077, 32'd3823026442, 32'd1066971017, 32'd3598330293, 32'd1979273937,
      32'd2079029895, 32'd1195045909, 32'd1071986421, 32'd2712821515, 32'd3377754595,
      32'd2184151095, 32'd750918864, 32'd2585729879, 32'd4249895712, 32'd1832579367,
      32'd1192240192, 32'd946734366, 32'd31230688, 32'd3174399083, 32'd3549375728,
      32'd1642430184, 32'd1904857554, 32'd861877404, 32'd3277825584, 32'd4267074718,
      32'd3122860549, 32'd666423581, 32'd644189126, 32'd226475395, 32'd307789415,
      32'd1196105631, 32'd3191691839, 32'd782852669, 32'd1608507813, 32'd1847685900,
      32'd4069766876, 32'd3931548641, 32'd2526471011, 32'd766865139, 32'd2115084288,
      32'd4259411376, 32'd3323683436, 32'd568512177, 32'd3736601419, 32'd1800276898,
      32'd4012458395, 32'd1823982, 32'd27980198, 32'd2023839966, 32'd869505096,
      32'd431161506, 32'd1024804023, 32'd1853869307, 32'd3393537983, 32'd1500703614,
      32'd3019471560, 32'd1351086955, 32'd3096933631, 32'd3034634988, 32'd2544598006,
      32'd1806067460, 32'd3022869466, 32'd3151669564, 32'd1385802998, 32'd1993153779,
      32'd3283153558, 32'd2052574289, 32'd1283286302, 32'd1839612224, 32'd2657584779,
      32'd2087622013, 32'd1005025990, 32'd2916716926, 32'd3004094446, 32'd3063307047,
      32'd3281962131, 32'd1604808426, 32'd2513649051, 32'd1931059622, 32'd1002766218,
      32'd1891981050, 32'd4049826380, 32'd4217567484, 32'd11706099, 32'd3812003425,
      32'd2931937003, 32'd1744562448, 32'd3654946539, 32'd898245616, 32'd1604741497,
      32'd2436649622, 32'd3066449520, 32'd1005060013, 32'd2917981574, 32'd2716632908,
      32'd3018722264, 32'd1897051998, 32'd2806713437, 32'd2733004880, 32'd1405218307,
      32'd3117862811, 32'd3059181066, 32'd1838195508, 32'd1713226547, 32'd2811617745,
      32'd1620127770, 32'd2637113584, 32'd3233669419, 32'd2434547013, 32'd2066010497,
      32'd1614342722, 32'd1493452015, 32'd1628008081, 32'd2932893542, 32'd3124617125,
      32'd3281982011, 32'd1713204484, 32'd4164045426, 32'd1005129869, 32'd4113289349,
      32'd2596640787
   };

   // One restoring remainder step: shift in a dividend bit, subtract if possible.
   function automatic logic [15:0] mod_step(input logic [15:0] rem, input logic dividend_bit,
                                            input logic [15:0] modulus);
      logic [16:0] acc;
      acc = {rem, dividend_bit};
      if (acc >= {1'b0, modulus}) begin
         acc = acc - {1'b0, modulus};
      end
      return acc[15:0];
   endfunction

   // Several remainder steps, most significant dividend bit first.
   function automatic logic [15:0] mod_digit(input logic [15:0] rem,
                                             input logic [BITS_PER_STAGE-1:0] digit,
                                             input logic [15:0] modulus);
      logic [15:0] r;
      r = rem;
      for (int i = BITS_PER_STAGE - 1; i >= 0; i--) begin
         r = mod_step(r, digit[i], modulus);
      end
      return r;
   endfunction

   function automatic logic [5:0] degree_of(input logic [19:0] v);
      logic [5:0] d;
      priority if (v < 20'd10241) begin
         d = 6'd1;
      end else if (v < 20'd491582) begin
         d = 6'd2;
      end else if (v < 20'd712794) begin
         d = 6'd3;
      end else if (v < 20'd831695) begin
         d = 6'd4;
      end else if (v < 20'd948446) begin
         d = 6'd10;
      end else if (v < 20'd1032189) begin
         d = 6'd11;
      end else begin
         d = 6'd40;
      end
      return d;
   endfunction

endpackage

### hw/rtl/rtg_channels.sv
// ----------------------------------------------------------------------------
// rtg_channels: valid/ready channels of the Raptor triple generator
// The request channel carries a symbol identifier, the response channel a
// triple of degree, stride and start index.
// ----------------------------------------------------------------------------
interface rtg_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] symbol_id;

   modport source (output valid, output symbol_id, input ready);
   modport sink (input valid, input symbol_id, output ready);
endinterface

interface rtg_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  degree;
   logic [13:0] step_a;
   logic [13:0] start_b;

   modport source (output valid, output degree, output step_a, output start_b, input ready);
   modport sink (input valid, input degree, input step_a, input start_b, output ready);
endinterface

### hw/rtl/raptor_triple_generator.sv
// ----------------------------------------------------------------------------
// raptor_triple_generator: RFC 5053 Raptor triple generator
// Each symbol identifier word on the request channel yields one word of
// (degree, step_a, start_b) on the response channel.
// ----------------------------------------------------------------------------
// Usage: software writes J, L and Q through the csr_ port while the block is
// idle. After reset and after every register write the block derives A and B
// from J and Q in a serial remainder unit, bit by bit; req_if.ready is low
// while it runs. After that one request word is taken in every cycle while
// rsp_if.ready does not hold the pipeline. The response word passes through
// twenty register stages: input register, one multiply-add stage, eight
// stages for the remainder modulo Q (four dividend bits per stage), one table
// stage and eight stages for the remainders modulo L-1 and L, then the output
// register. Throughput is one word per cycle when no stall holds the pipeline,
// set by the pipelined remainder stages. When the receiver holds rsp_if.ready
// low with a word waiting, the whole pipeline holds and req_if.ready falls;
// nothing is dropped or repeated.
// Reset is synchronous and restores J = 0, L = 3 and Q = 65521.
// ----------------------------------------------------------------------------
module raptor_triple_generator (
   input  logic                                clock,
   input  logic                                reset,
   rtg_req_if.sink                             req_if,
   rtg_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [rtg_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [rtg_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int NS = rtg_pkg::DIV_STAGES;
   localparam int DW = rtg_pkg::DIVIDEND_WIDTH;
   localparam int BS = rtg_pkg::BITS_PER_STAGE;

   // Configuration registers.
   logic [15:0] j_ff;
   logic [13:0] l_ff;
   logic [15:0] q_ff;

   // Serial unit for A and B.
   logic        load_ff;
   logic        busy_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] na_ff;
   logic [31:0] nb_ff;
   logic [15:0] ra_ff;
   logic [15:0] rb_ff;
   logic [15:0] a_val;
   logic [15:0] b_val;

   logic adv;

   logic        x_v_ff;
   logic [15:0] x_ff;
   logic        p_v_ff;
   logic [31:0] p_ff;
   logic [31:0] p_in;

   logic        yv_ff [NS];
   logic [15:0] yr_ff [NS];
   logic [31:0] yp_ff [NS];
   logic        yv_in [NS];
   logic [15:0] yr_in [NS];
   logic [31:0] yp_in [NS];
   logic [15:0] y_val;

   logic        t_v_ff;
   logic [31:0] w0_ff;
   logic [31:0] w1_ff;
   logic [31:0] w2_ff;
   logic [31:0] w0_in;
   logic [31:0] w1_in;
   logic [31:0] w2_in;

   logic        mv_ff [NS];
   logic [15:0] lr_ff [NS];
   logic [15:0] sr_ff [NS];
   logic [31:0] lp_ff [NS];
   logic [31:0] sp_ff [NS];
   logic [5:0]  dg_ff [NS];
   logic        mv_in [NS];
   logic [15:0] lr_in [NS];
   logic [15:0] sr_in [NS];
   logic [31:0] lp_in [NS];
   logic [31:0] sp_in [NS];
   logic [5:0]  dg_in [NS];

   logic [13:0] lm1;
   logic [15:0] lm1_w;
   logic [15:0] l_w;

   logic        out_v_ff;
   logic [5:0]  out_deg_ff;
   logic [13:0] out_step_ff;
   logic [13:0] out_start_ff;
   logic [13:0] step_in;
   logic [13:0] start_in;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= rtg_pkg::J_RESET;
         l_ff <= rtg_pkg::L_RESET;
         q_ff <= rtg_pkg::Q_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rtg_pkg::CSR_SYSTEMATIC_INDEX: j_ff <= csr_wdata;
            rtg_pkg::CSR_INTERMEDIATE:     l_ff <= csr_wdata[13:0];
            rtg_pkg::CSR_Q_MODULUS:        q_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------- A and B, one bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b1;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         load_ff <= csr_we;
         if (load_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ff) begin
         na_ff <= rtg_pkg::A_OFFSET + 32'(j_ff) * rtg_pkg::A_FACTOR;
         nb_ff <= rtg_pkg::B_FACTOR * (32'(j_ff) + 32'd1);
         ra_ff <= '0;
         rb_ff <= '0;
      end else if (busy_ff) begin
         na_ff <= {na_ff[30:0], 1'b0};
         nb_ff <= {nb_ff[30:0], 1'b0};
         ra_ff <= rtg_pkg::mod_step(ra_ff, na_ff[31], q_ff);
         rb_ff <= rtg_pkg::mod_step(rb_ff, nb_ff[31], q_ff);
      end
   end

   // A remainder by a zero modulus is defined as zero.
   assign a_val = (q_ff == 16'd0) ? 16'd0 : ra_ff;
   assign b_val = (q_ff == 16'd0) ? 16'd0 : rb_ff;

   // ------------------------------------------------------------------ pipeline
   assign adv          = !out_v_ff || rsp_if.ready;
   assign req_if.ready = adv && !busy_ff && !load_ff;

   assign p_in = 32'(x_ff) * 32'(a_val) + 32'(b_val);

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            yv_in[k] = p_v_ff;
            yr_in[k] = rtg_pkg::mod_digit(16'd0, p_ff[DW-1 -: BS], q_ff);
            yp_in[k] = p_ff << BS;
         end else begin
            yv_in[k] = yv_ff[k-1];
            yr_in[k] = rtg_pkg::mod_digit(yr_ff[k-1], yp_ff[k-1][DW-1 -: BS], q_ff);
            yp_in[k] = yp_ff[k-1] << BS;
         end
      end
   end

   assign y_val = (q_ff == 16'd0) ? 16'd0 : yr_ff[NS-1];

   // Rand words for i = 0, 1, 2; the table indices wrap at eight bits.
   assign w0_in = rtg_pkg::V0[y_val[7:0]] ^ rtg_pkg::V1[y_val[15:8]];
   assign w1_in = rtg_pkg::V0[8'(y_val[7:0] + 8'd1)] ^ rtg_pkg::V1[8'(y_val[15:8] + 8'd1)];
   assign w2_in = rtg_pkg::V0[8'(y_val[7:0] + 8'd2)] ^ rtg_pkg::V1[8'(y_val[15:8] + 8'd2)];

   assign lm1   = (l_ff == 14'd0) ? 14'd0 : l_ff - 14'd1;
   assign lm1_w = {2'b00, lm1};
   assign l_w   = {2'b00, l_ff};

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            mv_in[k] = t_v_ff;
            dg_in[k] = rtg_pkg::degree_of(w0_ff[19:0]);
            lr_in[k] = rtg_pkg::mod_digit(16'd0, w1_ff[DW-1 -: BS], lm1_w);
            sr_in[k] = rtg_pkg::mod_digit(16'd0, w2_ff[DW-1 -: BS], l_w);
            lp_in[k] = w1_ff << BS;
            sp_in[k] = w2_ff << BS;
         end else begin
            mv_in[k] = mv_ff[k-1];
            dg_in[k] = dg_ff[k-1];
            lr_in[k] = rtg_pkg::mod_digit(lr_ff[k-1], lp_ff[k-1][DW-1 -: BS], lm1_w);
            sr_in[k] = rtg_pkg::mod_digit(sr_ff[k-1], sp_ff[k-1][DW-1 -: BS], l_w);
            lp_in[k] = lp_ff[k-1] << BS;
            sp_in[k] = sp_ff[k-1] << BS;
         end
      end
   end

   assign step_in  = 14'd1 + ((lm1 == 14'd0) ? 14'd0 : lr_ff[NS-1][13:0]);
   assign start_in = (l_ff == 14'd0) ? 14'd0 : sr_ff[NS-1][13:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_v_ff   <= 1'b0;
         p_v_ff   <= 1'b0;
         t_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k < NS; k++) begin
            yv_ff[k] <= 1'b0;
            mv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         x_v_ff   <= req_if.valid && req_if.ready;
         p_v_ff   <= x_v_ff;
         t_v_ff   <= yv_ff[NS-1];
         out_v_ff <= mv_ff[NS-1];
         for (int k = 0; k < NS; k++) begin
            yv_ff[k] <= yv_in[k];
            mv_ff[k] <= mv_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff         <= req_if.symbol_id;
         p_ff         <= p_in;
         w0_ff        <= w0_in;
         w1_ff        <= w1_in;
         w2_ff        <= w2_in;
         out_deg_ff   <= dg_ff[NS-1];
         out_step_ff  <= step_in;
         out_start_ff <= start_in;
         for (int k = 0; k < NS; k++) begin
            yr_ff[k] <= yr_in[k];
            yp_ff[k] <= yp_in[k];
            lr_ff[k] <= lr_in[k];
            sr_ff[k] <= sr_in[k];
            lp_ff[k] <= lp_in[k];
            sp_ff[k] <= sp_in[k];
            dg_ff[k] <= dg_in[k];
         end
      end
   end

   assign rsp_if.valid   = out_v_ff;
   assign rsp_if.degree  = out_deg_ff;
   assign rsp_if.step_a  = out_step_ff;
   assign rsp_if.start_b = out_start_ff;

   // ---------------------------------------------------------------- assertions
   a_busy_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (busy_ff || load_ff) |-> !req_if.ready)
      else $error("request taken while A and B are being derived");

   a_cnt_only_busy : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 5'd0) |-> busy_ff)
      else $error("bit counter running outside the serial pass");

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> x_v_ff)
      else $error("accepted word did not enter the pipeline");

   a_degree_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.degree != 6'd0))
      else $error("response word carries a zero degree");

endmodule
